/* rtl/core/analog_stick_pointer_mapper_defines.svh */
// Assertion helpers for the stick mapper.
`ifndef ANALOG_STICK_POINTER_MAPPER_DEFINES_SVH
`define ANALOG_STICK_POINTER_MAPPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASP_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASP_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define ASP_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* rtl/core/asp_pkg.sv */
package asp_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int FULL_SCALE_DEF = 127;

    localparam logic [1:0] MODE_DIR    = 2'd0;
    localparam logic [1:0] MODE_PTR    = 2'd1;
    localparam logic [1:0] MODE_SCROLL = 2'd2;

    localparam logic [1:0] KIND_X     = 2'd0;
    localparam logic [1:0] KIND_Y     = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_ACT      = 3'd1;
    localparam logic [2:0] REG_HYST     = 3'd2;
    localparam logic [2:0] REG_MIN_SPD  = 3'd3;
    localparam logic [2:0] REG_MAX_SPD  = 3'd4;
    localparam logic [2:0] REG_SCRL_DIV = 3'd5;

    localparam logic [1:0] RPT_DIR    = 2'd0;
    localparam logic [1:0] RPT_PTR    = 2'd1;
    localparam logic [1:0] RPT_SCROLL = 2'd2;

    localparam logic [3:0] KEY_UP    = 4'b0001;
    localparam logic [3:0] KEY_DOWN  = 4'b0010;
    localparam logic [3:0] KEY_LEFT  = 4'b0100;
    localparam logic [3:0] KEY_RIGHT = 4'b1000;

    localparam logic [6:0]  ACT_RST  = 7'd64;
    localparam logic [6:0]  HYST_RST = 7'd16;
    localparam logic [15:0] MIN_RST  = 16'sd1;
    localparam logic [15:0] MAX_RST  = 16'sd16;
    localparam logic [15:0] DIV_RST  = 16'd4;
    localparam logic [15:0] DIV_ZERO_SUB = 16'd4;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_EVAL = 8'b00000010,
        S_DIV  = 8'b00000100,
        S_POST = 8'b00001000,
        S_MULX = 8'b00010000,
        S_MULY = 8'b00100000,
        S_ACC  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    // Division slots: pointer uses all three (speed, x unit, y unit),
    // scroll uses the first two (x, y).
    typedef enum logic [1:0] {
        OP_A = 2'd0,
        OP_B = 2'd1,
        OP_C = 2'd2
    } t_op;

endpackage

/* rtl/core/analog_stick_pointer_mapper.sv */
// Analog stick mapper. Axis transactions latch the signed X and Y deflection;
// a transaction with sync set evaluates the frame in the configured mode and
// yields at most one report. Direction mode reports newly pressed and released
// direction keys. Pointer mode runs three divisions (speed ramp, X unit, Y unit)
// through one shared restoring divider that retires one quotient bit per cycle.
// Scroll mode runs two divisions through the same divider. Transactions without
// sync, or of the "other axis" kind, start no evaluation.
// The input is not ready while a frame is being evaluated or its report waits.
module analog_stick_pointer_mapper #(
    parameter int FRAC_BITS  = asp_pkg::FRAC_BITS_DEF,
    parameter int FULL_SCALE = asp_pkg::FULL_SCALE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic signed [7:0] i_axis_value,
    input  logic        i_sync,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_report_type,
    output logic [3:0]  o_dirs_pressed,
    output logic [3:0]  o_dirs_released,
    output logic signed [15:0] o_delta_x,
    output logic signed [15:0] o_delta_y,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import asp_pkg::*;
    `include "analog_stick_pointer_mapper_defines.svh"

    // Magnitude width, dividend width and related sizes.
    localparam int MAGW = $clog2(FULL_SCALE + 1);
    localparam int CW   = (MAGW > 8) ? MAGW : 8;
    localparam int DW   = 16 + MAGW + FRAC_BITS;
    localparam int NW   = DW + 2;
    localparam int CNTW = $clog2(DW);
    localparam int UXW  = FRAC_BITS + 2;
    localparam int PW   = 32 + UXW;

    // Configuration registers.
    logic [1:0]         r_mode;
    logic [6:0]         r_act;
    logic [6:0]         r_hyst;
    logic signed [15:0] r_min_spd;
    logic signed [15:0] r_max_spd;
    logic [15:0]        r_scrl_div;

    // Frame state.
    logic signed [7:0]  r_sx;
    logic signed [7:0]  r_sy;
    logic [3:0]         r_held;
    logic signed [31:0] r_pacc_x, r_pacc_y, r_sacc_x, r_sacc_y;

    t_state r_state;
    t_op    r_op;

    // Shared divider.
    logic [DW-1:0]   r_quo;
    logic [15:0]     r_rem;
    logic [15:0]     r_dvs;
    logic            r_neg;
    logic [CNTW-1:0] r_cnt;

    // Working values.
    logic signed [31:0]    r_speed;
    logic signed [UXW-1:0] r_ux;
    logic signed [31:0]    r_dx, r_dy;

    // Output register.
    logic [1:0]         r_type;
    logic [3:0]         r_pr, r_rl;
    logic signed [15:0] r_odx, r_ody;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Adds d into acc with saturation and takes whole units out:
    // returns {units, new accumulator}.
    function automatic logic [47:0] take_units(input logic signed [31:0] acc,
                                               input logic signed [31:0] d);
        logic signed [31:0] a;
        logic signed [31:0] w;
        logic signed [15:0] wc;
        logic signed [31:0] na;
        a = sat32(64'(acc) + 64'(d));
        w = a >>> FRAC_BITS;
        if (w > 32'sd32767) begin
            wc = 16'sh7FFF;
        end else if (w < -32'sd32768) begin
            wc = -16'sh8000;
        end else begin
            wc = w[15:0];
        end
        na = sat32(64'(a) - (64'(wc) <<< FRAC_BITS));
        return {wc, na};
    endfunction

    // Magnitude estimate max + 3/8 min.
    logic [7:0]      ax, ay, hi, lo, raw;
    logic [9:0]      lo3;
    logic [CW-1:0]   mag_c;
    logic [MAGW-1:0] mm1;
    logic signed [16:0] diff;
    logic signed [17+MAGW:0] sprod;

    always_comb begin
        ax  = r_sx[7] ? 8'(-r_sx) : 8'(r_sx);
        ay  = r_sy[7] ? 8'(-r_sy) : 8'(r_sy);
        hi  = (ax > ay) ? ax : ay;
        lo  = (ax > ay) ? ay : ax;
        lo3 = {2'b0, lo} + {1'b0, lo, 1'b0};
        raw = hi + {1'b0, lo3[9:3]};
        mag_c = (CW'(raw) > CW'(FULL_SCALE)) ? CW'(FULL_SCALE) : CW'(raw);
        mm1  = MAGW'(mag_c) - MAGW'(1);
        diff = {r_max_spd[15], r_max_spd} - {r_min_spd[15], r_min_spd};
        sprod = diff * $signed({1'b0, mm1});
    end

    // Divider load for the next slot.
    t_op                ld_sel;
    logic signed [NW-1:0] ld_num, num_x, num_y, num_spd;
    logic [15:0]        ld_dvs, div_eff;
    logic               ld_neg;
    logic [DW-1:0]      ld_mag;

    always_comb begin
        ld_sel  = (r_state == S_EVAL) ? OP_A : ((r_op == OP_A) ? OP_B : OP_C);
        num_spd = $signed({sprod, {FRAC_BITS{1'b0}}});
        num_x   = $signed({{(NW-FRAC_BITS-8){r_sx[7]}}, r_sx, {FRAC_BITS{1'b0}}});
        num_y   = $signed({{(NW-FRAC_BITS-8){r_sy[7]}}, r_sy, {FRAC_BITS{1'b0}}});
        div_eff = (r_scrl_div == '0) ? DIV_ZERO_SUB : r_scrl_div;
        if (r_mode == MODE_PTR) begin
            case (ld_sel)
                OP_A: begin
                    ld_num = num_spd;
                    ld_dvs = 16'(FULL_SCALE - 1);
                end
                OP_B: begin
                    ld_num = num_x;
                    ld_dvs = {8'b0, raw};
                end
                default: begin
                    ld_num = num_y;
                    ld_dvs = {8'b0, raw};
                end
            endcase
        end else begin
            ld_num = (ld_sel == OP_A) ? num_x : num_y;
            ld_dvs = div_eff;
        end
        ld_neg = ld_num[NW-1];
        ld_mag = DW'(ld_neg ? -ld_num : ld_num);
    end

    // Divider step and signed quotient.
    logic [16:0]          dv_t;
    logic                 dv_ge;
    logic signed [DW:0]   qs;
    logic signed [31:0]   q32;

    always_comb begin
        dv_t  = {r_rem, r_quo[DW-1]};
        dv_ge = dv_t >= {1'b0, r_dvs};
        qs    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        q32   = sat32(64'(qs));
    end

    // Direction keys.
    logic [6:0]        deact;
    logic signed [8:0] pa, pd, sxw, syw;
    logic [3:0]        nd, pr, rl;

    always_comb begin
        deact = (r_act > r_hyst) ? (r_act - r_hyst) : 7'd0;
        pa  = $signed({2'b0, r_act});
        pd  = $signed({2'b0, deact});
        sxw = 9'(r_sx);
        syw = 9'(r_sy);
        nd  = '0;
        if (sxw > pa || ((r_held & KEY_RIGHT) != '0 && sxw > pd)) nd = nd | KEY_RIGHT;
        if (sxw < -pa || ((r_held & KEY_LEFT) != '0 && sxw < -pd)) nd = nd | KEY_LEFT;
        if (syw > pa || ((r_held & KEY_DOWN) != '0 && syw > pd)) nd = nd | KEY_DOWN;
        if (syw < -pa || ((r_held & KEY_UP) != '0 && syw < -pd)) nd = nd | KEY_UP;
        pr = nd & ~r_held;
        rl = r_held & ~nd;
    end

    // Pointer product, floored back to FRAC_BITS.
    logic signed [PW-1:0] mprod;
    logic signed [31:0]   mres;
    logic signed [31:0]   neg_y;

    always_comb begin
        mprod = r_speed * r_ux;
        mres  = sat32(64'(mprod >>> FRAC_BITS));
        neg_y = sat32(-64'(q32));
    end

    // Accumulator update.
    logic [47:0] tu_x, tu_y;
    logic        ptr_mode;

    always_comb begin
        ptr_mode = (r_mode == MODE_PTR);
        tu_x = take_units(ptr_mode ? r_pacc_x : r_sacc_x, r_dx);
        tu_y = take_units(ptr_mode ? r_pacc_y : r_sacc_y, r_dy);
    end

    // The last division of a frame leaves its quotient in the divider,
    // so the divider is not reloaded after it.
    logic in_acc, cfg_mode_wr, centered, last_op;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_mode_wr = i_cfg_we && (i_cfg_idx == REG_MODE);
    assign centered    = (r_sx == '0) && (r_sy == '0);
    assign last_op     = ptr_mode ? (r_op == OP_C) : (r_op == OP_B);

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_DIR;
            r_act      <= ACT_RST;
            r_hyst     <= HYST_RST;
            r_min_spd  <= MIN_RST;
            r_max_spd  <= MAX_RST;
            r_scrl_div <= DIV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:     r_mode     <= i_cfg_data[1:0];
                REG_ACT:      r_act      <= i_cfg_data[6:0];
                REG_HYST:     r_hyst     <= i_cfg_data[6:0];
                REG_MIN_SPD:  r_min_spd  <= i_cfg_data;
                REG_MAX_SPD:  r_max_spd  <= i_cfg_data;
                REG_SCRL_DIV: r_scrl_div <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, stick latches, held keys and accumulators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_A;
            r_sx     <= '0;
            r_sy     <= '0;
            r_held   <= '0;
            r_pacc_x <= '0;
            r_pacc_y <= '0;
            r_sacc_x <= '0;
            r_sacc_y <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind != KIND_OTHER) begin
                        if (i_kind == KIND_X) r_sx <= i_axis_value;
                        if (i_kind == KIND_Y) r_sy <= i_axis_value;
                        if (i_sync) r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (r_mode == MODE_DIR) begin
                        r_held <= nd;
                        if (pr != '0 || rl != '0) r_state <= S_OUT;
                    end else if (r_mode == MODE_PTR || r_mode == MODE_SCROLL) begin
                        if (centered) begin
                            if (ptr_mode) begin
                                r_pacc_x <= '0;
                                r_pacc_y <= '0;
                            end else begin
                                r_sacc_x <= '0;
                                r_sacc_y <= '0;
                            end
                        end else begin
                            r_op    <= OP_A;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) r_state <= S_POST;
                end
                S_POST: begin
                    r_op    <= ld_sel;
                    r_state <= S_DIV;
                    if (last_op) r_state <= ptr_mode ? S_MULX : S_ACC;
                end
                S_MULX: r_state <= S_MULY;
                S_MULY: r_state <= S_ACC;
                S_ACC: begin
                    if (ptr_mode) begin
                        r_pacc_x <= tu_x[31:0];
                        r_pacc_y <= tu_y[31:0];
                    end else begin
                        r_sacc_x <= tu_x[31:0];
                        r_sacc_y <= tu_y[31:0];
                    end
                    r_state <= (tu_x[47:32] != '0 || tu_y[47:32] != '0) ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Mode write drops held keys, fractions; user: idle only, unchecked.
            if (cfg_mode_wr) begin
                r_held   <= '0;
                r_pacc_x <= '0;
                r_pacc_y <= '0;
                r_sacc_x <= '0;
                r_sacc_y <= '0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL || (r_state == S_POST && !last_op)) begin
            r_quo <= ld_mag;
            r_rem <= '0;
            r_dvs <= ld_dvs;
            r_neg <= ld_neg;
            r_cnt <= CNTW'(DW - 1);
        end
        if (r_state == S_DIV) begin
            r_quo <= {r_quo[DW-2:0], dv_ge};
            r_rem <= dv_ge ? 16'(dv_t - {1'b0, r_dvs}) : dv_t[15:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (r_state == S_POST) begin
            if (ptr_mode) begin
                case (r_op)
                    OP_A: r_speed <= sat32(64'($signed({r_min_spd, {FRAC_BITS{1'b0}}}))
                                           + 64'(qs));
                    OP_B: r_ux <= qs[UXW-1:0];
                    default: ;
                endcase
            end else begin
                if (r_op == OP_A) r_dx <= q32;
                else r_dy <= neg_y;
            end
        end
        // The X unit is multiplied first; the Y unit still sits in the divider.
        if (r_state == S_MULX) begin
            r_dx <= mres;
            r_ux <= qs[UXW-1:0];
        end
        if (r_state == S_MULY) r_dy <= mres;
        if (r_state == S_EVAL) begin
            r_type <= RPT_DIR;
            r_pr   <= pr;
            r_rl   <= rl;
            r_odx  <= '0;
            r_ody  <= '0;
        end
        if (r_state == S_ACC) begin
            r_type <= ptr_mode ? RPT_PTR : RPT_SCROLL;
            r_pr   <= '0;
            r_rl   <= '0;
            r_odx  <= tu_x[47:32];
            r_ody  <= tu_y[47:32];
        end
    end

    assign o_out_valid     = (r_state == S_OUT);
    assign o_report_type   = r_type;
    assign o_dirs_pressed  = r_pr;
    assign o_dirs_released = r_rl;
    assign o_delta_x       = r_odx;
    assign o_delta_y       = r_ody;

    // Shape of a well-formed report of each kind.
    logic rpt_dir_ok, rpt_move_ok;
    assign rpt_dir_ok  = (o_dirs_pressed | o_dirs_released) != '0
                         && o_delta_x == '0 && o_delta_y == '0;
    assign rpt_move_ok = (o_delta_x != '0 || o_delta_y != '0)
                         && o_dirs_pressed == '0 && o_dirs_released == '0;

    `ASP_ASSERT_IMPLY(a_one_at_a_time, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `ASP_ASSERT_IMPLY(a_dir_nonempty, i_clk, i_rst_n, o_out_valid && o_report_type == RPT_DIR, rpt_dir_ok)
    `ASP_ASSERT_IMPLY(a_move_nonzero, i_clk, i_rst_n, o_out_valid && o_report_type != RPT_DIR, rpt_move_ok)
    `ASP_ASSERT_NEXT(a_back_to_idle, i_clk, i_rst_n, o_out_valid && i_out_ready, o_in_ready && !o_out_valid)

endmodule

/* verif/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import asp_pkg::*;

    // One stick transaction as the driver presents it.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] axis;
        logic       sync;
    } stick_evt_t;

    // One report as the block presents it.
    typedef struct packed {
        logic [1:0]  rtype;
        logic [3:0]  pressed;
        logic [3:0]  released;
        logic [15:0] dx;
        logic [15:0] dy;
    } stick_rpt_t;

    localparam int  FRAC = 16;
    localparam int  FS = 127;
    localparam int  IDLE_LIMIT = 20000;
    localparam logic [1:0] KIND_EVENT = 2'd3;
    localparam logic [1:0] MODE_OFF = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic signed [7:0] axis_value;
    logic        sync;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  report_type;
    logic [3:0]  dirs_pressed;
    logic [3:0]  dirs_released;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;

    analog_stick_pointer_mapper dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_axis_value(axis_value), .i_sync(sync),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_report_type(report_type), .o_dirs_pressed(dirs_pressed),
        .o_dirs_released(dirs_released), .o_delta_x(delta_x), .o_delta_y(delta_y),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Shadow copy of the configuration and state, updated as transactions
    // are accepted so that expectations follow the block exactly.
    logic [1:0]  m_mode;
    logic [6:0]  m_act;
    logic [6:0]  m_hyst;
    logic signed [15:0] m_min;
    logic signed [15:0] m_max;
    logic [15:0] m_div;
    logic signed [7:0] m_x;
    logic signed [7:0] m_y;
    logic [3:0]  m_held;
    logic signed [31:0] m_pacc_x, m_pacc_y, m_sacc_x, m_sacc_y;

    stick_evt_t pending_evts[$];
    stick_rpt_t expected_rpts[$];
    int  error_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  stall_cycles;

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Floor toward minus infinity of a value holding FRAC fraction bits.
    function automatic logic signed [63:0] whole_floor(input logic signed [63:0] v);
        return v >>> FRAC;
    endfunction

    // Adds into an accumulator, pulls whole units out with saturation at 16 bits.
    function automatic logic signed [15:0] drain_units(
        ref logic signed [31:0] acc, input logic signed [63:0] d);
        logic signed [31:0] a;
        logic signed [63:0] w;
        a = sat32(64'(acc) + d);
        w = whole_floor(64'(a));
        if (w > 64'sd32767) w = 64'sd32767;
        if (w < -64'sd32768) w = -64'sd32768;
        acc = sat32(64'(a) - (w <<< FRAC));
        return w[15:0];
    endfunction

    function automatic void clear_motion();
        m_held = '0;
        m_pacc_x = '0; m_pacc_y = '0;
        m_sacc_x = '0; m_sacc_y = '0;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:     begin m_mode = val[1:0]; clear_motion(); end
            REG_ACT:      m_act = val[6:0];
            REG_HYST:     m_hyst = val[6:0];
            REG_MIN_SPD:  m_min = val;
            REG_MAX_SPD:  m_max = val;
            REG_SCRL_DIV: m_div = val;
            default: ;
        endcase
    endtask

    // Works out the report, if any, that one accepted transaction causes.
    function automatic void predict_frame(input stick_evt_t e);
        stick_rpt_t r;
        int act, deact;
        logic [3:0] nd, pr, rl;
        logic signed [63:0] ax, ay, hi, lo, raw, mag, speed, ux, uy, dvx, dvy, dv;
        logic signed [15:0] px, py;
        if (e.kind == KIND_OTHER) return;
        if (e.kind == KIND_X) m_x = e.axis;
        if (e.kind == KIND_Y) m_y = e.axis;
        if (!e.sync) return;
        r = '0;
        case (m_mode)
            MODE_DIR: begin
                act = m_act;
                deact = act - int'(m_hyst);
                if (deact < 0) deact = 0;
                nd = '0;
                if (m_x > act || (m_held[3] && m_x > deact)) nd |= KEY_RIGHT;
                if (m_x < -act || (m_held[2] && m_x < -deact)) nd |= KEY_LEFT;
                if (m_y > act || (m_held[1] && m_y > deact)) nd |= KEY_DOWN;
                if (m_y < -act || (m_held[0] && m_y < -deact)) nd |= KEY_UP;
                pr = nd & ~m_held;
                rl = m_held & ~nd;
                m_held = nd;
                if (pr != 0 || rl != 0) begin
                    r.rtype = RPT_DIR; r.pressed = pr; r.released = rl;
                    expected_rpts.push_back(r);
                end
            end
            MODE_PTR: begin
                if (m_x == 0 && m_y == 0) begin
                    m_pacc_x = '0; m_pacc_y = '0;
                    return;
                end
                ax = (m_x < 0) ? -64'(m_x) : 64'(m_x);
                ay = (m_y < 0) ? -64'(m_y) : 64'(m_y);
                hi = (ax > ay) ? ax : ay;
                lo = (ax > ay) ? ay : ax;
                raw = hi + ((lo * 3) >>> 3);
                mag = (raw > FS) ? FS : raw;
                speed = 64'(m_min) <<< FRAC;
                if (mag > 1)
                    speed += ((64'(m_max) - 64'(m_min)) * (mag - 1) * (64'sd1 <<< FRAC))
                             / (FS - 1);
                speed = 64'(sat32(speed));
                ux = (64'(m_x) <<< FRAC) / raw;
                uy = (64'(m_y) <<< FRAC) / raw;
                dvx = 64'(sat32(whole_floor(speed * ux)));
                dvy = 64'(sat32(whole_floor(speed * uy)));
                px = drain_units(m_pacc_x, dvx);
                py = drain_units(m_pacc_y, dvy);
                if (px != 0 || py != 0) begin
                    r.rtype = RPT_PTR; r.dx = px; r.dy = py;
                    expected_rpts.push_back(r);
                end
            end
            MODE_SCROLL: begin
                if (m_x == 0 && m_y == 0) begin
                    m_sacc_x = '0; m_sacc_y = '0;
                    return;
                end
                // A zero divisor falls back to four.
                dv = (m_div == 0) ? 64'sd4 : 64'(m_div);
                dvx = 64'(sat32((64'(m_x) <<< FRAC) / dv));
                dvy = 64'(sat32(-64'(sat32((64'(m_y) <<< FRAC) / dv))));
                px = drain_units(m_sacc_x, dvx);
                py = drain_units(m_sacc_y, dvy);
                if (px != 0 || py != 0) begin
                    r.rtype = RPT_SCROLL; r.dx = px; r.dy = py;
                    expected_rpts.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    // Driver: presents queued transactions, idling at random between them.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            kind       <= '0;
            axis_value <= '0;
            sync       <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) predict_frame(pending_evts.pop_front());
            if (pending_evts.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_valid   <= 1'b1;
                kind       <= pending_evts[0].kind;
                axis_value <= pending_evts[0].axis;
                sync       <= pending_evts[0].sync;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted report and throttles the report side.
    always @(posedge clk) begin
        stick_rpt_t exp_r;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_rpts.size() == 0) begin
                    report_mismatch("report with none expected");
                end else begin
                    exp_r = expected_rpts.pop_front();
                    if (report_type !== exp_r.rtype)
                        report_mismatch($sformatf("type %0d exp %0d", report_type, exp_r.rtype));
                    if (dirs_pressed !== exp_r.pressed)
                        report_mismatch($sformatf("pressed %b exp %b",
                                                  dirs_pressed, exp_r.pressed));
                    if (dirs_released !== exp_r.released)
                        report_mismatch($sformatf("released %b exp %b",
                                                  dirs_released, exp_r.released));
                    if (delta_x !== exp_r.dx)
                        report_mismatch($sformatf("dx %0d exp %0d", delta_x,
                                                  $signed(exp_r.dx)));
                    if (delta_y !== exp_r.dy)
                        report_mismatch($sformatf("dy %0d exp %0d", delta_y,
                                                  $signed(exp_r.dy)));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: any cycle without a handshake on either side or a configuration write counts.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    function automatic stick_evt_t mk_evt(input logic [1:0] k, input logic [7:0] a,
                                          input logic s);
        stick_evt_t e;
        e.kind = k; e.axis = a; e.sync = s;
        return e;
    endfunction

    // Random axis value, biased toward the extremes and the center.
    function automatic logic [7:0] rand_axis();
        case ($urandom_range(9))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h00;
            3: return 8'($signed($urandom_range(6)) - 3);
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames (X, Y, sync) with occasional noise.
    task automatic queue_random_frames(input int n);
        repeat (n) begin
            case ($urandom_range(9))
                0: pending_evts.push_back(mk_evt(KIND_OTHER, 8'($urandom), 1'($urandom)));
                1: pending_evts.push_back(mk_evt(KIND_EVENT, 8'($urandom), 1'($urandom)));
                2: pending_evts.push_back(mk_evt(2'($urandom), rand_axis(), 1'($urandom)));
                default: begin
                    pending_evts.push_back(mk_evt(KIND_X, rand_axis(), 1'b0));
                    pending_evts.push_back(mk_evt(KIND_Y, rand_axis(), 1'b1));
                end
            endcase
        end
    endtask

    // Waits until the driver has drained and every report has arrived,
    // then lets the block finish a report-less evaluation.
    task automatic settle();
        while (pending_evts.size() != 0 || in_valid || expected_rpts.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // Runs one phase: configuration while idle, then frames.
    task automatic run_phase(input logic [1:0] md, input logic [6:0] act,
                             input logic [6:0] hy, input logic [15:0] mn,
                             input logic [15:0] mx, input logic [15:0] dv, input int n);
        write_reg(REG_ACT, 16'(act));
        write_reg(REG_HYST, 16'(hy));
        write_reg(REG_MIN_SPD, mn);
        write_reg(REG_MAX_SPD, mx);
        write_reg(REG_SCRL_DIV, dv);
        write_reg(REG_MODE, 16'(md));
        queue_random_frames(n);
        settle();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        send_idle_pct = 13; recv_idle_pct = 77;
        m_mode = MODE_DIR; m_act = ACT_RST; m_hyst = HYST_RST;
        m_min = MIN_RST; m_max = MAX_RST; m_div = DIV_RST;
        m_x = '0; m_y = '0;
        clear_motion();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset-default direction mode, hysteresis holding a key,
        // every kind, other-axis with sync dropped, then each mode's extremes.
        pending_evts.push_back(mk_evt(KIND_X, 8'h7f, 1'b1));
        pending_evts.push_back(mk_evt(KIND_X, 8'd60, 1'b1));
        pending_evts.push_back(mk_evt(KIND_X, 8'd40, 1'b1));
        pending_evts.push_back(mk_evt(KIND_Y, 8'h80, 1'b0));
        pending_evts.push_back(mk_evt(KIND_OTHER, 8'h00, 1'b1));
        pending_evts.push_back(mk_evt(KIND_EVENT, 8'h55, 1'b1));
        pending_evts.push_back(mk_evt(KIND_X, 8'h80, 1'b1));
        pending_evts.push_back(mk_evt(KIND_Y, 8'h00, 1'b1));
        settle();
        write_reg(REG_MODE, 16'(MODE_PTR));
        pending_evts.push_back(mk_evt(KIND_X, 8'h7f, 1'b0));
        pending_evts.push_back(mk_evt(KIND_Y, 8'h80, 1'b1));
        pending_evts.push_back(mk_evt(KIND_X, 8'h01, 1'b0));
        pending_evts.push_back(mk_evt(KIND_Y, 8'h00, 1'b1));
        pending_evts.push_back(mk_evt(KIND_X, 8'h00, 1'b1));
        settle();
        write_reg(REG_MODE, 16'(MODE_SCROLL));
        pending_evts.push_back(mk_evt(KIND_X, 8'h80, 1'b0));
        pending_evts.push_back(mk_evt(KIND_Y, 8'h7f, 1'b1));
        pending_evts.push_back(mk_evt(KIND_EVENT, 8'h00, 1'b1));
        settle();
        write_reg(REG_MODE, 16'(MODE_OFF));
        pending_evts.push_back(mk_evt(KIND_X, 8'h7f, 1'b1));
        settle();

        // Random phases across register extremes and idling profiles.
        run_phase(MODE_DIR, 7'd0, 7'd0, 16'd1, 16'd16, 16'd4, 104);
        run_phase(MODE_DIR, 7'd127, 7'd127, 16'd1, 16'd16, 16'd4, 78);
        run_phase(MODE_PTR, 7'd64, 7'd16, 16'h8000, 16'h7fff, 16'd0, 78);
        run_phase(MODE_PTR, 7'd64, 7'd16, 16'h7fff, 16'h8000, 16'hffff, 52);
        send_idle_pct = 77; recv_idle_pct = 13;
        run_phase(MODE_PTR, 7'd30, 7'd5, 16'd1, 16'd16, 16'd1, 78);
        run_phase(MODE_SCROLL, 7'd30, 7'd5, 16'd0, 16'd0, 16'd0, 78);
        run_phase(MODE_SCROLL, 7'd30, 7'd5, 16'd0, 16'd0, 16'hffff, 52);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_phase(MODE_SCROLL, 7'd10, 7'd20, 16'd3, 16'd3, 16'd1, 52);
        run_phase(MODE_DIR, 7'($urandom), 7'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom_range(40)), 78);
        run_phase(MODE_PTR, 7'd64, 7'd16, 16'($urandom), 16'($urandom), 16'd4, 65);
        run_phase(MODE_OFF, 7'd64, 7'd16, 16'd1, 16'd16, 16'd4, 13);

        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/asp_pkg.sv
rtl/core/analog_stick_pointer_mapper.sv
verif/tb_top.sv
